@@ sv/gabm_pkg.sv @@
// shared types, constants and helpers for the graph adjacency bit matrix block
// depends on nothing; imported by gabm_row_unit, the top module and the bench

package gabm_pkg;

    // graph size; the vertex index fields derived from it are 4 bits wide
    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int ECNT_W       = 7;
    localparam int CMD_W        = 3;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_V = 3'd0,
        CMD_DEL_V = 3'd1,
        CMD_ADD_E = 3'd2,
        CMD_DEL_E = 3'd3,
        CMD_QRY_V = 3'd4,
        CMD_QRY_E = 3'd5
    } cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_CNT  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // request context handed to the row unit
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [VIDX_W-1:0] a;
        logic [VIDX_W-1:0] hi;
        logic [VIDX_W-1:0] lo;
        logic              self_loop;
    } row_ctrl_t;

    // per-row outcome from the row unit
    typedef struct packed {
        logic [MAX_VERTICES-1:0] row_new;
        logic                    wr;
        logic [MAX_VERTICES-1:0] nb_old;
        logic [MAX_VERTICES-1:0] nb_new;
        logic                    hit_hi;
        logic                    edge_bit;
        logic                    edge_inc;
        logic                    edge_dec;
    } row_res_t;

    // population count of one row
    function automatic logic [VCNT_W-1:0] popcount(input logic [MAX_VERTICES-1:0] v);
        logic [VCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            n = n + VCNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

@@ sv/gabm_ram.sv @@
// generic single-write, single-read RAM with registered read data
// no dependencies

module gabm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gabm_row_unit.sv @@
// row update unit: applies one request to one matrix row and extracts neighbor bits
// depends on gabm_pkg

module gabm_row_unit
    import gabm_pkg::*;
(
    input  row_ctrl_t               ctrl,
    input  logic [VIDX_W-1:0]       row_idx,
    input  logic [MAX_VERTICES-1:0] row_in,
    output row_res_t                res
);

    logic [MAX_VERTICES-1:0] row_new;
    logic [MAX_VERTICES-1:0] low_mask;
    logic [MAX_VERTICES-1:0] row_bit;
    logic                    is_a;
    logic                    above_a;
    logic                    is_hi;

    assign is_a     = (row_idx == ctrl.a);
    assign above_a  = (row_idx > ctrl.a);
    assign is_hi    = (row_idx == ctrl.hi);
    assign low_mask = (MAX_VERTICES'(1) << ctrl.a) - MAX_VERTICES'(1);
    assign row_bit  = MAX_VERTICES'(1) << row_idx;

    // row modification per command
    always_comb
    begin
        row_new = row_in;
        unique case (ctrl.cmd)
            CMD_DEL_V:
            begin
                if (is_a)
                begin
                    row_new = '0;
                end
                else if (above_a)
                begin
                    row_new[ctrl.a] = 1'b0;
                end
            end
            CMD_ADD_E:
            begin
                if (is_hi && !ctrl.self_loop)
                begin
                    row_new[ctrl.lo] = 1'b1;
                end
            end
            CMD_DEL_E:
            begin
                if (is_hi && !ctrl.self_loop)
                begin
                    row_new[ctrl.lo] = 1'b0;
                end
            end
            default:
            begin
                row_new = row_in;
            end
        endcase
    end

    // neighbor bits of vertex a before and after the update
    always_comb
    begin
        res.row_new = row_new;
        res.wr      = (row_new != row_in);
        res.nb_old  = '0;
        res.nb_new  = '0;
        if (is_a)
        begin
            res.nb_old = row_in & low_mask;
            res.nb_new = row_new & low_mask;
        end
        else if (above_a)
        begin
            res.nb_old = row_in[ctrl.a] ? row_bit : '0;
            res.nb_new = row_new[ctrl.a] ? row_bit : '0;
        end
        res.hit_hi   = is_hi;
        res.edge_bit = row_new[ctrl.lo] && !ctrl.self_loop;
        // single-edge count changes; a vertex delete is counted from its old neighbors
        res.edge_inc = is_hi && (ctrl.cmd == CMD_ADD_E) &&
                       !row_in[ctrl.lo] && row_new[ctrl.lo];
        res.edge_dec = is_hi && (ctrl.cmd == CMD_DEL_E) &&
                       row_in[ctrl.lo] && !row_new[ctrl.lo];
    end

endmodule

@@ sv/graph_adjacency_bit_matrix.sv @@
// graph of up to 16 vertices: lower-triangular adjacency bit matrix plus vertex set
// one request at a time; the next start is taken in the cycle the done strobe is high
// each request walks the 16 matrix rows through one RAM read port (ST_WALK), then
// uses the shared popcount unit for removed edges (ST_CNT) and then the degree
// (ST_DONE); the done strobe is registered from ST_DONE
// reset (async, active low) empties the vertex set, the matrix and the edge count;
// results come with a single-cycle done strobe and the receiver cannot stall them
// depends on gabm_pkg, gabm_ram, gabm_row_unit

module graph_adjacency_bit_matrix
    import gabm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        command,
    input  logic [VIDX_W-1:0]       vertex_a,
    input  logic [VIDX_W-1:0]       vertex_b,
    output logic                    done,
    output logic                    vertex_present,
    output logic [VIDX_W-1:0]       vertex_degree_out,
    output logic [MAX_VERTICES-1:0] neighbor_mask,
    output logic                    edge_present,
    output logic [VCNT_W-1:0]       vertex_count,
    output logic [ECNT_W-1:0]       edge_count,
    output logic                    status
);

    state_t                  state_reg, state_next;
    logic [VIDX_W-1:0]       idx_reg;
    row_ctrl_t               ctrl_reg;
    logic                    status_reg;
    logic [MAX_VERTICES-1:0] vset_reg;
    logic [VCNT_W-1:0]       vcount_reg;
    logic [ECNT_W-1:0]       edge_total_reg;
    logic [MAX_VERTICES-1:0] nb_old_reg;
    logic [MAX_VERTICES-1:0] nb_new_reg;
    logic                    edge_hit_reg;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic                    rd_valid_reg;
    logic                    done_reg;
    logic                    present_out_reg;
    logic [VIDX_W-1:0]       degree_out_reg;
    logic [MAX_VERTICES-1:0] mask_out_reg;
    logic                    edge_out_reg;
    logic [VCNT_W-1:0]       vcount_out_reg;
    logic [ECNT_W-1:0]       ecount_out_reg;
    logic                    status_out_reg;

    logic                    accept;
    logic [VIDX_W-1:0]       rd_addr;
    logic [MAX_VERTICES-1:0] ram_q;
    logic [MAX_VERTICES-1:0] row_cur;
    logic                    ram_we;
    row_res_t                row_res;
    logic [MAX_VERTICES-1:0] pc_in;
    logic [VCNT_W-1:0]       pc_out;
    logic                    req_self;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // matrix row storage
    assign rd_addr = (state_reg == ST_WALK) ? idx_reg + VIDX_W'(1) : '0;
    assign ram_we  = (state_reg == ST_WALK) && row_res.wr;

    gabm_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (row_res.row_new),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // rows never written since reset read as empty
    assign row_cur = rd_valid_reg ? ram_q : '0;

    gabm_row_unit u_row (
        .ctrl    (ctrl_reg),
        .row_idx (idx_reg),
        .row_in  (row_cur),
        .res     (row_res)
    );

    // shared popcount: removed edges in the count step, degree in the final step
    assign pc_in  = (state_reg == ST_CNT) ? nb_old_reg : nb_new_reg;
    assign pc_out = popcount(pc_in);

    // self-loop flag for edge commands
    assign req_self = (vertex_a == vertex_b) &&
                      ((command == CMD_ADD_E) || (command == CMD_DEL_E) ||
                       (command == CMD_QRY_E));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == VIDX_W'(MAX_VERTICES - 1))
                begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // row valid bits and read-side valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ram_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // vertex set and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vset_reg       <= '0;
            vcount_reg     <= '0;
            edge_total_reg <= '0;
        end
        else
        begin
            if (accept && (command == CMD_ADD_V) && !vset_reg[vertex_a])
            begin
                vset_reg[vertex_a] <= 1'b1;
                vcount_reg         <= vcount_reg + VCNT_W'(1);
            end
            else if (accept && (command == CMD_DEL_V) && vset_reg[vertex_a])
            begin
                vset_reg[vertex_a] <= 1'b0;
                vcount_reg         <= vcount_reg - VCNT_W'(1);
            end
            if (state_reg == ST_WALK && row_res.edge_inc)
            begin
                edge_total_reg <= edge_total_reg + ECNT_W'(1);
            end
            else if (state_reg == ST_WALK && row_res.edge_dec)
            begin
                edge_total_reg <= edge_total_reg - ECNT_W'(1);
            end
            else if (state_reg == ST_CNT && ctrl_reg.cmd == CMD_DEL_V)
            begin
                edge_total_reg <= edge_total_reg - ECNT_W'(pc_out);
            end
        end
    end

    // request context and walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg <= '0;
        end
        else if (state_reg == ST_WALK)
        begin
            idx_reg <= idx_reg + VIDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg.cmd       <= command;
            ctrl_reg.a         <= vertex_a;
            ctrl_reg.hi        <= (vertex_a > vertex_b) ? vertex_a : vertex_b;
            ctrl_reg.lo        <= (vertex_a > vertex_b) ? vertex_b : vertex_a;
            ctrl_reg.self_loop <= (vertex_a == vertex_b);
            status_reg         <= req_self;
        end
    end

    // neighbor and edge collection during the walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nb_old_reg   <= '0;
            nb_new_reg   <= '0;
            edge_hit_reg <= 1'b0;
        end
        else if (state_reg == ST_WALK)
        begin
            nb_old_reg <= nb_old_reg | row_res.nb_old;
            nb_new_reg <= nb_new_reg | row_res.nb_new;
            if (row_res.hit_hi)
            begin
                edge_hit_reg <= row_res.edge_bit;
            end
        end
    end

    // result registers and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            present_out_reg <= vset_reg[ctrl_reg.a];
            degree_out_reg  <= pc_out[VIDX_W-1:0];
            mask_out_reg    <= nb_new_reg;
            edge_out_reg    <= edge_hit_reg;
            vcount_out_reg  <= vcount_reg;
            ecount_out_reg  <= edge_total_reg;
            status_out_reg  <= status_reg;
        end
    end

    assign done              = done_reg;
    assign vertex_present    = present_out_reg;
    assign vertex_degree_out = degree_out_reg;
    assign neighbor_mask     = mask_out_reg;
    assign edge_present      = edge_out_reg;
    assign vertex_count      = vcount_out_reg;
    assign edge_count        = ecount_out_reg;
    assign status            = status_out_reg;

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start the walk");

    a_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WALK))
        else $error("matrix row written outside the walk");

    a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg == popcount(vset_reg))
        else $error("vertex count out of step with vertex set");

    a_ecount: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECNT_W'(120))
        else $error("edge count beyond the matrix capacity");

endmodule

@@ sim/graph_adjacency_bit_matrix_test.sv @@
// self-checking bench for graph_adjacency_bit_matrix: directed, full-graph and random requests
// depends on gabm_pkg and the graph_adjacency_bit_matrix rtl; keeps its own graph copy

module graph_adjacency_bit_matrix_test;
    import gabm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;

    // one expected report from the block
    typedef struct {
        cmd_t        cmd;
        logic [3:0]  a;
        logic [3:0]  b;
        logic        vertex_present;
        logic [3:0]  degree;
        logic [15:0] neighbors;
        logic        edge_present;
        logic [4:0]  vertex_total;
        logic [6:0]  edge_total;
        logic        self_loop;
    } graph_report_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        command;
    logic [3:0]  vertex_a;
    logic [3:0]  vertex_b;
    logic        done;
    logic        vertex_present;
    logic [3:0]  vertex_degree_out;
    logic [15:0] neighbor_mask;
    logic        edge_present;
    logic [4:0]  vertex_count;
    logic [6:0]  edge_count;
    logic        status;

    // graph copy kept by the bench
    logic [15:0] rows_model [16];
    logic [15:0] vertex_bits;
    int unsigned edges_stored;

    graph_report_t pending_reports[$];
    int unsigned   requests_sent;
    int unsigned   reports_checked;
    int unsigned   peak_edges;
    int unsigned   burst_left;
    bit            failed;

    graph_adjacency_bit_matrix u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .vertex_a          (vertex_a),
        .vertex_b          (vertex_b),
        .done              (done),
        .vertex_present    (vertex_present),
        .vertex_degree_out (vertex_degree_out),
        .neighbor_mask     (neighbor_mask),
        .edge_present      (edge_present),
        .vertex_count      (vertex_count),
        .edge_count        (edge_count),
        .status            (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // edge lookup in the lower-triangular matrix
    function automatic logic edge_between(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        if (a == b)
            return 1'b0;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return rows_model[hi][lo];
    endfunction

    // set or clear one edge, counting only real changes
    function automatic void write_edge(input logic [3:0] a, input logic [3:0] b, input logic on);
        logic [3:0] hi;
        logic [3:0] lo;
        logic       was;
        hi  = (a > b) ? a : b;
        lo  = (a > b) ? b : a;
        was = edge_between(a, b);
        if (on && !was)
        begin
            rows_model[hi][lo] = 1'b1;
            edges_stored++;
        end
        else if (!on && was)
        begin
            rows_model[hi][lo] = 1'b0;
            edges_stored--;
        end
    endfunction

    // neighbors: low part of own row plus column bits of the rows above
    function automatic logic [15:0] neighbors_of_vertex(input logic [3:0] v);
        logic [15:0] m;
        m = rows_model[v] & ((16'd1 << v) - 16'd1);
        for (int r = int'(v) + 1; r < 16; r++)
        begin
            if (rows_model[r][v])
                m[r] = 1'b1;
        end
        return m;
    endfunction

    // apply one request to the graph copy and build the report it should give
    function automatic graph_report_t apply_graph_command(input cmd_t c, input logic [3:0] a,
                                                          input logic [3:0] b);
        graph_report_t rep;
        logic          loop_flag;
        loop_flag = 1'b0;
        case (c)
            CMD_ADD_V: vertex_bits[a] = 1'b1;
            CMD_DEL_V:
            begin
                vertex_bits[a] = 1'b0;
                for (int r = 0; r < 16; r++)
                begin
                    if (r != int'(a))
                        write_edge(a, 4'(r), 1'b0);
                end
                rows_model[a] = '0;
            end
            CMD_ADD_E, CMD_DEL_E:
            begin
                if (a == b)
                    loop_flag = 1'b1;
                else
                    write_edge(a, b, c == CMD_ADD_E);
            end
            CMD_QRY_E: loop_flag = (a == b);
            default: ;
        endcase
        rep.cmd            = c;
        rep.a              = a;
        rep.b              = b;
        rep.neighbors      = neighbors_of_vertex(a);
        rep.vertex_present = vertex_bits[a];
        rep.degree         = 4'($countones(rep.neighbors));
        rep.edge_present   = edge_between(a, b);
        rep.vertex_total   = 5'($countones(vertex_bits));
        rep.edge_total     = 7'(edges_stored);
        rep.self_loop      = loop_flag;
        if (edges_stored > peak_edges)
            peak_edges = edges_stored;
        return rep;
    endfunction

    // drive one request, bursts separated by random idle gaps
    task automatic send_request(input cmd_t c, input logic [3:0] a, input logic [3:0] b);
        if (burst_left == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 28)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        start    <= 1'b1;
        command  <= c;
        vertex_a <= a;
        vertex_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_reports.push_back(apply_graph_command(c, a, b));
        requests_sent++;
        burst_left--;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // report checker
    always @(posedge clk)
    begin
        graph_report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with no request outstanding", $time);
                failed = 1'b1;
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                compare_field("vertex_present", want.vertex_present, vertex_present);
                compare_field("vertex_degree_out", want.degree, vertex_degree_out);
                compare_field("neighbor_mask", want.neighbors, neighbor_mask);
                compare_field("edge_present", want.edge_present, edge_present);
                compare_field("vertex_count", want.vertex_total, vertex_count);
                compare_field("edge_count", want.edge_total, edge_count);
                compare_field("status", want.self_loop, status);
            end
        end
    end

    // extremes and corner cases on a fresh graph
    task automatic test_directed();
        send_request(CMD_QRY_V, 4'd0, 4'd0);
        send_request(CMD_ADD_V, 4'd0, 4'd15);
        send_request(CMD_ADD_V, 4'd15, 4'd0);
        send_request(CMD_ADD_V, 4'd0, 4'd0);
        send_request(CMD_ADD_E, 4'd0, 4'd15);
        send_request(CMD_ADD_E, 4'd15, 4'd0);
        send_request(CMD_QRY_E, 4'd0, 4'd15);
        // self-loop on every edge command
        send_request(CMD_ADD_E, 4'd5, 4'd5);
        send_request(CMD_DEL_E, 4'd5, 4'd5);
        send_request(CMD_QRY_E, 4'd5, 4'd5);
        // edges touching vertices never added
        send_request(CMD_ADD_E, 4'd3, 4'd7);
        send_request(CMD_QRY_V, 4'd7, 4'd3);
        send_request(CMD_DEL_E, 4'd7, 4'd3);
        send_request(CMD_DEL_E, 4'd3, 4'd7);
        send_request(CMD_ADD_E, 4'd15, 4'd9);
        send_request(CMD_QRY_V, 4'd15, 4'd0);
        // vertex delete drops its edges, repeated delete is a no-op
        send_request(CMD_DEL_V, 4'd15, 4'd0);
        send_request(CMD_DEL_V, 4'd15, 4'd0);
        send_request(CMD_DEL_V, 4'd9, 4'd9);
        send_request(CMD_QRY_E, 4'd15, 4'd15);
        send_request(CMD_QRY_V, 4'd0, 4'd15);
    endtask

    // complete graph on all vertices, then tear it down vertex by vertex
    task automatic test_full_graph();
        for (int v = 0; v < 16; v++)
            send_request(CMD_ADD_V, 4'(v), 4'(15 - v));
        for (int hi = 1; hi < 16; hi++)
        begin
            for (int lo = 0; lo < hi; lo++)
            begin
                if ($urandom_range(0, 1))
                    send_request(CMD_ADD_E, 4'(hi), 4'(lo));
                else
                    send_request(CMD_ADD_E, 4'(lo), 4'(hi));
            end
        end
        for (int v = 0; v < 16; v++)
            send_request(CMD_QRY_V, 4'(v), 4'($urandom_range(0, 15)));
        for (int v = 15; v >= 0; v--)
            send_request(CMD_DEL_V, 4'(v), 4'($urandom_range(0, 15)));
    endtask

    function automatic logic [3:0] pick_vertex(input int unsigned span);
        return 4'($urandom_range(0, span));
    endfunction

    // random mix, indices often drawn from a narrow window so edges collide
    task automatic test_random(input int unsigned count);
        int unsigned roll;
        int unsigned span;
        logic [3:0]  a;
        logic [3:0]  b;
        cmd_t        c;
        for (int unsigned i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            span = ($urandom_range(0, 1) == 0) ? 5 : 15;
            a    = pick_vertex(span);
            b    = pick_vertex(span);
            if ($urandom_range(0, 19) == 0)
                b = a;
            if (roll < 15)
                c = CMD_ADD_V;
            else if (roll < 21)
                c = CMD_DEL_V;
            else if (roll < 56)
                c = CMD_ADD_E;
            else if (roll < 71)
                c = CMD_DEL_E;
            else if (roll < 85)
                c = CMD_QRY_V;
            else
                c = CMD_QRY_E;
            send_request(c, a, b);
        end
    endtask

    // watchdog on cycles with neither a request nor a report
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("graph_adjacency_bit_matrix_test failed");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_ADD_V;
        vertex_a   = '0;
        vertex_b   = '0;
        vertex_bits = '0;
        edges_stored = 0;
        for (int r = 0; r < 16; r++)
            rows_model[r] = '0;
        requests_sent   = 0;
        reports_checked = 0;
        peak_edges      = 0;
        burst_left      = 0;
        failed          = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_graph();
        test_random(950);

        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests, checked %0d reports", requests_sent, reports_checked);
        $display("largest edge count reached: %0d", peak_edges);
        if (!failed)
            $display("graph_adjacency_bit_matrix_test passed");
        else
            $display("graph_adjacency_bit_matrix_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gabm_pkg.sv
sv/gabm_ram.sv
sv/gabm_row_unit.sv
sv/graph_adjacency_bit_matrix.sv
sim/graph_adjacency_bit_matrix_test.sv
